[hw/rtl/fob_pkg.sv]
//------------------------------------------------------------------------------
// fob_pkg: shared types and constants of the flight observation builder
// Payload structs, configuration register indexes, CORDIC angle table.
//------------------------------------------------------------------------------
package fob_pkg;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] comp_a;
    logic signed [31:0] comp_b;
    logic signed [31:0] comp_c;
    logic signed [31:0] comp_d;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [4:0]         index;
    logic               last;
  } out_word_t;

  localparam logic [2:0] RegLayout  = 3'd0;
  localparam logic [2:0] RegTargetX = 3'd1;
  localparam logic [2:0] RegTargetY = 3'd2;
  localparam logic [2:0] RegTargetZ = 3'd3;
  localparam logic [2:0] RegClip    = 3'd4;

  localparam logic [1:0] FuncPos  = 2'd0;
  localparam logic [1:0] FuncVel  = 2'd1;
  localparam logic [1:0] FuncGyro = 2'd2;
  localparam logic [1:0] FuncQuat = 2'd3;

  localparam int CordicSteps = 17;
  localparam logic signed [19:0] PiQ     = 20'sd205887;
  localparam logic signed [19:0] HalfPiQ = 20'sd102944;
  localparam logic signed [34:0] DegToRad = 35'sd74961321;

  function automatic logic signed [19:0] atan_tab(input logic [4:0] i);
    logic signed [19:0] r;
    begin
      case (i)
        5'd0: r = 20'sd51472;
        5'd1: r = 20'sd30386;
        5'd2: r = 20'sd16055;
        5'd3: r = 20'sd8150;
        5'd4: r = 20'sd4091;
        5'd5: r = 20'sd2047;
        5'd6: r = 20'sd1024;
        5'd7: r = 20'sd512;
        5'd8: r = 20'sd256;
        5'd9: r = 20'sd128;
        5'd10: r = 20'sd64;
        5'd11: r = 20'sd32;
        5'd12: r = 20'sd16;
        5'd13: r = 20'sd8;
        5'd14: r = 20'sd4;
        5'd15: r = 20'sd2;
        5'd16: r = 20'sd1;
        default: r = 20'sd0;
      endcase
      return r;
    end
  endfunction

endpackage

[hw/rtl/fob_mul.sv]
//------------------------------------------------------------------------------
// fob_mul: shared registered multiplier
// One 35x35 signed product per cycle, result registered.
//------------------------------------------------------------------------------
module fob_mul (
  input  logic               clk_i,
  input  logic signed [34:0] a_i,
  input  logic signed [34:0] b_i,
  output logic signed [69:0] p_o
);
  always_ff @(posedge clk_i) begin
    p_o <= a_i * b_i;
  end
endmodule

[hw/rtl/fob_cordic.sv]
//------------------------------------------------------------------------------
// fob_cordic: iterative CORDIC atan2
// One vectoring step per cycle, 17 steps after the operands are loaded.
//------------------------------------------------------------------------------
module fob_cordic (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [32:0] y_i,
  input  logic signed [32:0] x_i,
  output logic               done_o,
  output logic signed [19:0] ang_o
);
  // Growth over 17 steps stays below 2^35 for 33-bit magnitudes.
  logic signed [35:0] x_q, y_q;
  logic signed [19:0] ang_q;
  logic [4:0]         step_q;
  logic               busy_q;
  logic signed [35:0] xs, ys;

  assign xs = x_q >>> step_q;
  assign ys = y_q >>> step_q;
  assign ang_o = ang_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      step_q <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        step_q <= '0;
        if (y_i == 0) begin
          ang_q  <= (x_i < 0) ? fob_pkg::PiQ : 20'sd0;
          done_o <= 1'b1;
        end else if (x_i == 0) begin
          ang_q  <= (y_i > 0) ? fob_pkg::HalfPiQ : -fob_pkg::HalfPiQ;
          done_o <= 1'b1;
        end else if (x_i < 0) begin
          ang_q  <= (y_i >= 0) ? fob_pkg::PiQ : -fob_pkg::PiQ;
          x_q    <= -36'(x_i);
          y_q    <= -36'(y_i);
          busy_q <= 1'b1;
        end else begin
          ang_q  <= 20'sd0;
          x_q    <= 36'(x_i);
          y_q    <= 36'(y_i);
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        if (y_q > 0) begin
          x_q   <= x_q + ys;
          y_q   <= y_q - xs;
          ang_q <= ang_q + fob_pkg::atan_tab(step_q);
        end else begin
          x_q   <= x_q - ys;
          y_q   <= y_q + xs;
          ang_q <= ang_q - fob_pkg::atan_tab(step_q);
        end
        if (step_q == 5'(fob_pkg::CordicSteps - 1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end else begin
          step_q <= step_q + 5'd1;
        end
      end
    end
  end
endmodule

[hw/rtl/fob_isqrt.sv]
//------------------------------------------------------------------------------
// fob_isqrt: iterative integer square root
// One result bit per cycle, 32 result bits over a 64-bit radicand.
//------------------------------------------------------------------------------
module fob_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] rad_i,
  output logic        done_o,
  output logic [31:0] root_o
);
  logic [63:0] rem_q, res_q, bit_q;
  logic        busy_q;
  logic [63:0] trial;

  assign trial  = res_q + bit_q;
  assign root_o = res_q[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        rem_q  <= rad_i;
        res_q  <= '0;
        bit_q  <= 64'd1 << 62;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (rem_q >= trial) begin
          rem_q <= rem_q - trial;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
        if (bit_q[0]) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end
endmodule

[hw/rtl/flight_observation_builder_top.sv]
//------------------------------------------------------------------------------
// flight_observation_builder_top: observation vector builder
// Stores position error, velocity and rates; on a quaternion word builds the
// rotation matrix and roll, pitch, yaw and streams the observation vector.
//------------------------------------------------------------------------------
//   channel | direction | handshake         | payload
//   in      | input     | in_valid/in_ready | fob_pkg::in_word_t
//   out     | output    | out_valid/ready   | fob_pkg::out_word_t
//   cfg     | input     | cfg_valid/ready   | cfg_index_i, cfg_data_i
//
// A position or velocity word is accepted and then stored. A gyro word is
// accepted and then takes three multiply and write pairs on the shared
// multiplier. A quaternion word takes the nine products, the matrix, the
// two squares of the square root's radicand, the square root and three
// CORDIC runs, then streams the elements through the output register, one
// per cycle while the output is ready. The three CORDIC runs set the bulk.
// Reset clears the stored position, velocity and rates and loads the register
// defaults. A stalled output holds the sequencer; the block takes no new word
// until the vector has gone out.
module flight_observation_builder_top #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  fob_pkg::in_word_t    in_data_i,
  output logic                 out_valid,
  input  logic                 out_ready,
  output fob_pkg::out_word_t   out_data_o,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index_i,
  input  logic [31:0]          cfg_data_i
);
  localparam int VW = VALUE_WIDTH;
  localparam logic signed [69:0] VMax = 70'sd1 <<< (VW - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_MWAIT, S_STORE, S_MAT, S_SQRT, S_CORD, S_EMIT
  } state_e;

  state_e             state_q;
  fob_pkg::in_word_t  in_q;
  logic [1:0]         layout_q;
  logic signed [31:0] tgt_q [3];
  logic [30:0]        clip_q;
  logic signed [VW-1:0] pos_q [3], vel_q [3], rate_q [3];
  logic signed [VW-1:0] mat_q [9];
  logic signed [VW-1:0] ang_q [3];
  logic signed [69:0] prod_q [9];
  logic [3:0]         cnt_q;
  logic [4:0]         idx_q, total_q;
  logic [1:0]         ang_sel_q;
  logic [31:0]        root_q;
  logic [63:0]        sq_acc_q;

  // Saturate a wide value to VW bits.
  function automatic logic signed [VW-1:0] sat(input logic signed [69:0] v);
    if (v > VMax - 70'sd1) return VMax[VW-1:0] - 1'b1;
    if (v < -VMax) return VMax[VW-1:0];
    return v[VW-1:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [VW-1:0] v);
    logic signed [69:0] e;
    e = 70'(v);
    if (e > 70'sd2147483647) return 32'sh7fffffff;
    if (e < -70'sd2147483648) return 32'sh80000000;
    return e[31:0];
  endfunction

  logic signed [31:0] m7s, m8s;
  assign m7s = sat32(mat_q[7]);
  assign m8s = sat32(mat_q[8]);

  // Shared multiplier operand selection.
  logic signed [34:0] ma, mb;
  logic signed [69:0] mp;
  fob_mul u_mul (.clk_i, .a_i(ma), .b_i(mb), .p_o(mp));

  always_comb begin
    ma = 35'(in_q.comp_a);
    mb = 35'(in_q.comp_a);
    if (in_q.func == fob_pkg::FuncGyro) begin
      ma = fob_pkg::DegToRad;
      case (cnt_q)
        4'd0: mb = 35'(in_q.comp_a);
        4'd1: mb = 35'(in_q.comp_b);
        default: mb = 35'(in_q.comp_c);
      endcase
    end else begin
      // w=a x=b y=c z=d: xx yy zz xy xz yz xw yw zw, then m7*m7 and m8*m8
      case (cnt_q)
        4'd0: begin ma = 35'(in_q.comp_b); mb = 35'(in_q.comp_b); end
        4'd1: begin ma = 35'(in_q.comp_c); mb = 35'(in_q.comp_c); end
        4'd2: begin ma = 35'(in_q.comp_d); mb = 35'(in_q.comp_d); end
        4'd3: begin ma = 35'(in_q.comp_b); mb = 35'(in_q.comp_c); end
        4'd4: begin ma = 35'(in_q.comp_b); mb = 35'(in_q.comp_d); end
        4'd5: begin ma = 35'(in_q.comp_c); mb = 35'(in_q.comp_d); end
        4'd6: begin ma = 35'(in_q.comp_b); mb = 35'(in_q.comp_a); end
        4'd7: begin ma = 35'(in_q.comp_c); mb = 35'(in_q.comp_a); end
        4'd8: begin ma = 35'(in_q.comp_d); mb = 35'(in_q.comp_a); end
        4'd9: begin ma = 35'(m7s); mb = 35'(m7s); end
        default: begin ma = 35'(m8s); mb = 35'(m8s); end
      endcase
    end
  end

  // Rounded products. q16 rounding and the gyro 2^32 rounding.
  logic signed [69:0] q [9];
  always_comb begin
    for (int i = 0; i < 9; i++) q[i] = (prod_q[i] + 70'sd32768) >>> 16;
  end
  logic signed [69:0] rad_r;
  assign rad_r = (mp + 70'sh80000000) >>> 32;

  // Matrix from products, element m[k].
  logic signed [69:0] mraw [9];
  always_comb begin
    mraw[0] = 70'sd65536 - 2*q[0] - 2*q[2];
    mraw[1] = -(2*q[3] + 2*q[8]);
    mraw[2] = -(2*q[5] - 2*q[6]);
    mraw[3] = -(2*q[3] - 2*q[8]);
    mraw[4] = 70'sd65536 - 2*q[1] - 2*q[2];
    mraw[5] = 2*q[4] + 2*q[7];
    mraw[6] = -(2*q[5] + 2*q[6]);
    mraw[7] = 2*q[4] - 2*q[7];
    mraw[8] = 70'sd65536 - 2*q[0] - 2*q[1];
  end

  // The radicand is the stored m7 square plus the m8 square leaving the
  // multiplier in the cycle that starts the square root.
  logic [63:0] sq_rad;
  assign sq_rad = sq_acc_q + mp[63:0];

  logic sq_start, sq_done, co_start, co_done;
  logic [31:0] sq_root;
  logic signed [32:0] co_y, co_x;
  logic signed [19:0] co_ang;
  logic [1:0]         co_sel;

  fob_isqrt u_sqrt (.clk_i, .rst_ni, .start_i(sq_start), .rad_i(sq_rad),
                    .done_o(sq_done), .root_o(sq_root));
  fob_cordic u_cordic (.clk_i, .rst_ni, .start_i(co_start), .y_i(co_y),
                       .x_i(co_x), .done_o(co_done), .ang_o(co_ang));

  // The operands follow the angle about to be started, not the one running.
  assign co_sel = (state_q == S_SQRT) ? 2'd0 : ang_sel_q + 2'd1;

  always_comb begin
    case (co_sel)
      2'd0: begin co_y = 33'(m7s); co_x = 33'(m8s); end
      2'd1: begin co_y = -33'(sat32(mat_q[6])); co_x = $signed({1'b0, root_q}); end
      default: begin co_y = 33'(sat32(mat_q[3])); co_x = 33'(sat32(mat_q[0])); end
    endcase
  end

  // Element selection for the output stream.
  logic signed [VW-1:0] elem;
  logic [4:0] rel;
  always_comb begin
    rel  = idx_q;
    elem = rate_q[0];
    if (layout_q == 2'd3) begin
      if (rel < 5'd3) elem = pos_q[rel[1:0]];
      rel = rel - 5'd3;
    end
    if (layout_q != 2'd3 || idx_q >= 5'd3) begin
      if (layout_q != 2'd0 && rel < 5'd9) begin
        case (rel[3:0])
          4'd0: elem = mat_q[0];
          4'd1: elem = mat_q[3];
          4'd2: elem = mat_q[6];
          4'd3: elem = mat_q[1];
          4'd4: elem = mat_q[4];
          4'd5: elem = mat_q[7];
          4'd6: elem = mat_q[2];
          4'd7: elem = mat_q[5];
          default: elem = mat_q[8];
        endcase
      end else begin
        if (layout_q != 2'd0) rel = rel - 5'd9;
        if (layout_q != 2'd0 && rel < 5'd3) elem = ang_q[rel[1:0]];
        else begin
          if (layout_q != 2'd0) rel = rel - 5'd3;
          if (layout_q[1] && rel < 5'd3) elem = vel_q[rel[1:0]];
          else begin
            if (layout_q[1]) rel = rel - 5'd3;
            elem = rate_q[rel[1:0]];
          end
        end
      end
    end
  end

  assign in_ready  = (state_q == S_IDLE);
  assign cfg_ready = 1'b1;
  assign sq_start  = (state_q == S_MWAIT) && (in_q.func == fob_pkg::FuncQuat) &&
                     (cnt_q == 4'd10);
  assign co_start  = (state_q == S_SQRT && sq_done) ||
                     (state_q == S_CORD && co_done && ang_sel_q != 2'd2);

  logic signed [33:0] e0, e1, e2;
  logic signed [33:0] cl;
  assign e0 = -34'(in_q.comp_b) - 34'(tgt_q[0]);
  assign e1 = 34'(in_q.comp_a) - 34'(tgt_q[1]);
  assign e2 = 34'(in_q.comp_c) - 34'(tgt_q[2]);
  assign cl = 34'(clip_q);

  function automatic logic signed [69:0] clipv(input logic signed [33:0] v,
                                               input logic signed [33:0] c);
    if (v < -c) return 70'(-c);
    if (v > c) return 70'(c);
    return 70'(v);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      layout_q  <= 2'd3;
      tgt_q     <= '{default: '0};
      clip_q    <= 31'd19661;
      pos_q     <= '{default: '0};
      vel_q     <= '{default: '0};
      rate_q    <= '{default: '0};
      cnt_q     <= '0;
      idx_q     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index_i)
          fob_pkg::RegLayout:  layout_q <= cfg_data_i[1:0];
          fob_pkg::RegTargetX: tgt_q[0] <= cfg_data_i;
          fob_pkg::RegTargetY: tgt_q[1] <= cfg_data_i;
          fob_pkg::RegTargetZ: tgt_q[2] <= cfg_data_i;
          fob_pkg::RegClip:    clip_q   <= cfg_data_i[30:0];
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: if (in_valid) begin
          in_q  <= in_data_i;
          cnt_q <= '0;
          unique case (in_data_i.func)
            fob_pkg::FuncPos:  state_q <= S_STORE;
            fob_pkg::FuncVel:  state_q <= S_STORE;
            fob_pkg::FuncGyro: state_q <= S_MUL;
            default:           state_q <= S_MUL;
          endcase
        end
        S_MUL: state_q <= S_MWAIT;
        S_MWAIT: begin
          if (in_q.func == fob_pkg::FuncGyro) begin
            case (cnt_q)
              4'd0: rate_q[0] <= sat(rad_r);
              4'd1: rate_q[1] <= sat(-rad_r);
              default: rate_q[2] <= sat(-rad_r);
            endcase
            if (cnt_q == 4'd2) state_q <= S_IDLE;
            else begin cnt_q <= cnt_q + 4'd1; state_q <= S_MUL; end
          end else if (cnt_q < 4'd9) begin
            prod_q[cnt_q] <= mp;
            if (cnt_q == 4'd8) state_q <= S_MAT;
            else begin cnt_q <= cnt_q + 4'd1; state_q <= S_MUL; end
          end else if (cnt_q == 4'd9) begin
            sq_acc_q <= mp[63:0];
            cnt_q    <= 4'd10;
            state_q  <= S_MUL;
          end else begin
            // The square root starts on this edge.
            state_q <= S_SQRT;
          end
        end
        S_STORE: begin
          if (in_q.func == fob_pkg::FuncPos) begin
            pos_q[0] <= sat(clipv(e0, cl));
            pos_q[1] <= sat(clipv(e1, cl));
            pos_q[2] <= sat(clipv(e2, cl));
          end else begin
            vel_q[0] <= sat(-70'(in_q.comp_b));
            vel_q[1] <= sat(70'(in_q.comp_a));
            vel_q[2] <= sat(70'(in_q.comp_c));
          end
          state_q <= S_IDLE;
        end
        S_MAT: begin
          for (int i = 0; i < 9; i++) mat_q[i] <= sat(mraw[i]);
          cnt_q   <= 4'd9;
          state_q <= S_MUL;
        end
        S_SQRT: begin
          // The radicand was captured when the square root started.
          if (sq_done) begin
            root_q    <= sq_root;
            ang_sel_q <= 2'd0;
            state_q   <= S_CORD;
          end
        end
        S_CORD: if (co_done) begin
          ang_q[ang_sel_q] <= sat(70'(co_ang));
          if (ang_sel_q == 2'd2) begin
            idx_q   <= '0;
            total_q <= (layout_q == 2'd0) ? 5'd3 : (layout_q == 2'd1) ? 5'd15 :
                       (layout_q == 2'd2) ? 5'd18 : 5'd21;
            state_q <= S_EMIT;
          end else begin
            ang_sel_q <= ang_sel_q + 2'd1;
          end
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            if (idx_q == total_q) begin
              out_valid <= 1'b0;
              state_q   <= S_IDLE;
            end else begin
              out_valid <= 1'b1;
              out_data_o.value <= 32'(elem);
              out_data_o.index <= idx_q;
              out_data_o.last  <= (idx_q + 5'd1 == total_q);
              idx_q <= idx_q + 5'd1;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

[hw/rtl/fob_checker.sv]
//------------------------------------------------------------------------------
// fob_checker: port-level checks of the observation builder
// Watches the handshakes and output words at the top level.
//------------------------------------------------------------------------------
module fob_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input fob_pkg::out_word_t out_data_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data_o))
    else $error("output word changed while stalled");
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready)
    else $error("input taken while vector streams");
  a_index_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_data_o.index <= 5'd20)
    else $error("element index out of range");
  a_index_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready && !out_data_o.last ##1 out_valid |->
    out_data_o.index == $past(out_data_o.index) + 5'd1)
    else $error("element index skipped");
endmodule

bind flight_observation_builder_top fob_checker u_fob_checker (.*);
